/* hw/rtl/rpb_pkg.sv */
// Shared types, sizes and codes for the register read plan builder.
`default_nettype none

package rpb_pkg;

  // Table size and address space.
  localparam int unsigned MAX_RANGES = 32;
  localparam int unsigned ADDR_SPACE = 65536;
  localparam int unsigned IDX_W      = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);

  // Field widths fixed by the interface.
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned END_W   = 17;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned REQ_W   = 11;
  localparam int unsigned CFG_W   = 11;

  // Request size limits.
  localparam logic [REQ_W-1:0] REQ_CAP   = REQ_W'(2000);
  localparam logic [REQ_W-1:0] MPR_RESET = REQ_W'(125);

  // Command codes.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // Result status codes, also used as the pending error code.
  localparam logic [1:0] STATUS_REQ      = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
  localparam logic [1:0] STATUS_NO_PLAN  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_MAX_PER_REQ = 1'b0;
  localparam logic CFG_AREA        = 1'b1;

  // One input item.
  typedef struct packed {
    logic               cmd;
    logic [ADDR_W-1:0]  range_start;
    logic [COUNT_W-1:0] range_count;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]        status;
    logic              area;
    logic [ADDR_W-1:0] req_start;
    logic [REQ_W-1:0]  req_count;
    logic              last;
  } out_item_t;

  // One stored range: first address and exclusive end.
  typedef struct packed {
    logic [ADDR_W-1:0] range_start;
    logic [END_W-1:0]  range_end;
  } range_t;

  // Controls from the sequencer to the range table.
  typedef struct packed {
    logic             ins_en;
    range_t           ins;
    logic [CNT_W-1:0] total;
    logic [IDX_W-1:0] rd_idx;
  } tbl_req_t;

endpackage

`default_nettype wire

/* hw/rtl/rpb_cell.sv */
// One cell of the sorted range table: holds one range and shifts right on insert.
`default_nettype none

module rpb_cell (
  input  wire logic            clk_i,
  input  wire logic            ins_en_i,
  input  wire rpb_pkg::range_t ins_i,
  input  wire logic            beyond_i,
  input  wire rpb_pkg::range_t left_i,
  input  wire logic            left_after_i,
  output rpb_pkg::range_t      entry_o,
  output logic                 after_o
);
  import rpb_pkg::*;

  range_t entry_q;

  // This cell sits at or after the insert point if it is empty or holds a larger start.
  assign after_o = beyond_i || (entry_q.range_start > ins_i.range_start);
  assign entry_o = entry_q;

  // On insert, cells past the insert point take their left neighbor, the first one
  // at the insert point takes the new range.
  always_ff @(posedge clk_i) begin
    if (ins_en_i) begin
      if (left_after_i) begin
        entry_q <= left_i;
      end else if (after_o) begin
        entry_q <= ins_i;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rpb_table.sv */
// Row of range cells kept sorted by start, with a read port for the plan walk.
`default_nettype none

module rpb_table (
  input  wire logic              clk_i,
  input  wire rpb_pkg::tbl_req_t req_i,
  output rpb_pkg::range_t        rd_entry_o
);
  import rpb_pkg::*;

  range_t entry [MAX_RANGES];
  logic   after [MAX_RANGES];

  // Chain of cells, each fed by its left neighbor.
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    range_t left_entry;
    logic   left_after;
    logic   beyond;

    assign beyond = (CNT_W'(i) >= req_i.total);

    if (i == 0) begin : g_head
      assign left_entry = req_i.ins;
      assign left_after = 1'b0;
    end else begin : g_body
      assign left_entry = entry[i-1];
      assign left_after = after[i-1];
    end

    rpb_cell u_cell (
      .clk_i        (clk_i),
      .ins_en_i     (req_i.ins_en),
      .ins_i        (req_i.ins),
      .beyond_i     (beyond),
      .left_i       (left_entry),
      .left_after_i (left_after),
      .entry_o      (entry[i]),
      .after_o      (after[i])
    );
  end

  // Read the entry under the fetch cursor.
  assign rd_entry_o = entry[req_i.rd_idx];

endmodule

`default_nettype wire

/* hw/rtl/register_read_plan_builder.sv */
// Top level: sequencer for adding ranges and walking the read plan.
// Add: the range is stored in the execute state; the next item enters once back in idle.
// Fetch: an error or an empty plan goes from execute to emit, a request of an open segment
// goes through chunk, and opening a segment walks open, merge (one entry per cycle), chunk.
// The next item enters once emit registers the result; a stalled output delays that.
// Reset clears the table count, error, readout and configuration (125, area 0).
`default_nettype none

module register_read_plan_builder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rpb_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rpb_pkg::out_item_t      out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [rpb_pkg::CFG_W-1:0] cfg_data_i
);
  import rpb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OPEN,
    ST_MERGE,
    ST_CHUNK,
    ST_EMIT
  } state_e;

  state_e            state_q;
  in_item_t          item_q;
  logic [REQ_W-1:0]  mpr_q;
  logic              area_q;
  logic [CNT_W-1:0]  total_q;
  logic [1:0]        err_q;
  logic [CNT_W-1:0]  cursor_q;
  logic [END_W-1:0]  seg_next_q;
  logic [END_W-1:0]  seg_end_q;
  logic              seg_open_q;
  out_item_t         res_q;
  out_item_t         out_q;
  logic              out_valid_q;

  tbl_req_t          tbl_req;
  range_t            rd_entry;

  logic [END_W:0]    add_end;
  logic              add_bad;
  logic              add_ok;
  logic [REQ_W-1:0]  cap;
  logic [END_W-1:0]  rest;
  logic [REQ_W-1:0]  chunk_n;
  logic [END_W-1:0]  next_sum;
  logic              still_open;
  logic              plan_last;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Add checks: zero count or an end past the address space.
  assign add_end = (END_W+1)'(item_q.range_start) + (END_W+1)'(item_q.range_count);
  assign add_bad = (item_q.range_count == '0) || (add_end > (END_W+1)'(ADDR_SPACE));
  assign add_ok  = (state_q == ST_EXEC) && (item_q.cmd == CMD_ADD) && (err_q == STATUS_REQ)
                   && !add_bad && (total_q < CNT_W'(MAX_RANGES));

  // Table controls.
  always_comb begin
    tbl_req.ins_en            = add_ok;
    tbl_req.ins.range_start   = item_q.range_start;
    tbl_req.ins.range_end     = add_end[END_W-1:0];
    tbl_req.total             = total_q;
    tbl_req.rd_idx            = cursor_q[IDX_W-1:0];
  end

  rpb_table u_table (
    .clk_i      (clk_i),
    .req_i      (tbl_req),
    .rd_entry_o (rd_entry)
  );

  // Request size: clamp the limit, then take the smaller of limit and what is left.
  always_comb begin
    if (mpr_q == '0) begin
      cap = REQ_W'(1);
    end else if (mpr_q > REQ_CAP) begin
      cap = REQ_CAP;
    end else begin
      cap = mpr_q;
    end
    rest       = seg_end_q - seg_next_q;
    chunk_n    = (rest < END_W'(cap)) ? rest[REQ_W-1:0] : cap;
    next_sum   = seg_next_q + END_W'(chunk_n);
    still_open = next_sum < seg_end_q;
    plan_last  = !still_open && (cursor_q >= total_q);
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Sequencer, plan state, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      mpr_q       <= MPR_RESET;
      area_q      <= 1'b0;
      total_q     <= '0;
      err_q       <= STATUS_REQ;
      cursor_q    <= '0;
      seg_next_q  <= '0;
      seg_end_q   <= '0;
      seg_open_q  <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_PER_REQ: mpr_q  <= cfg_data_i;
          CFG_AREA:        area_q <= cfg_data_i[0];
          default:         ;
        endcase
      end

      // Result leaves when the far side takes it, unless the emit state refills it.
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            item_q  <= in_item_i;
            state_q <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          res_q.area      <= area_q;
          res_q.req_start <= '0;
          res_q.req_count <= '0;
          res_q.last      <= 1'b1;
          if (item_q.cmd == CMD_ADD) begin
            // First error sticks; a stored range rewinds the readout.
            if (err_q == STATUS_REQ) begin
              if (add_bad) begin
                err_q <= STATUS_INVALID;
              end else if (!add_ok) begin
                err_q <= STATUS_OVERFLOW;
              end else begin
                total_q    <= total_q + CNT_W'(1);
                cursor_q   <= '0;
                seg_next_q <= '0;
                seg_end_q  <= '0;
                seg_open_q <= 1'b0;
              end
            end
            state_q <= ST_IDLE;
          end else if (err_q != STATUS_REQ) begin
            // Report the error and drop the whole plan.
            res_q.status <= err_q;
            err_q        <= STATUS_REQ;
            total_q      <= '0;
            cursor_q     <= '0;
            seg_next_q   <= '0;
            seg_end_q    <= '0;
            seg_open_q   <= 1'b0;
            state_q      <= ST_EMIT;
          end else if (!seg_open_q && (cursor_q >= total_q)) begin
            cursor_q   <= '0;
            seg_next_q <= '0;
            seg_end_q  <= '0;
            if (total_q == '0) begin
              res_q.status <= STATUS_NO_PLAN;
              state_q      <= ST_EMIT;
            end else begin
              state_q <= ST_OPEN;
            end
          end else if (!seg_open_q) begin
            state_q <= ST_OPEN;
          end else begin
            state_q <= ST_CHUNK;
          end
        end

        // Start a segment at the entry under the cursor.
        ST_OPEN: begin
          seg_next_q <= END_W'(rd_entry.range_start);
          seg_end_q  <= rd_entry.range_end;
          cursor_q   <= cursor_q + CNT_W'(1);
          state_q    <= ST_MERGE;
        end

        // Fold following ranges that touch or overlap into the segment.
        ST_MERGE: begin
          if ((cursor_q < total_q) && (END_W'(rd_entry.range_start) <= seg_end_q)) begin
            if (rd_entry.range_end > seg_end_q) begin
              seg_end_q <= rd_entry.range_end;
            end
            cursor_q <= cursor_q + CNT_W'(1);
          end else begin
            seg_open_q <= 1'b1;
            state_q    <= ST_CHUNK;
          end
        end

        // Cut one request off the open segment.
        ST_CHUNK: begin
          res_q.status    <= STATUS_REQ;
          res_q.req_start <= seg_next_q[ADDR_W-1:0];
          res_q.req_count <= chunk_n;
          res_q.last      <= plan_last;
          if (plan_last) begin
            cursor_q   <= '0;
            seg_next_q <= '0;
            seg_end_q  <= '0;
            seg_open_q <= 1'b0;
          end else begin
            seg_next_q <= next_sum;
            seg_open_q <= still_open;
          end
          state_q <= ST_EMIT;
        end

        // Hand the result to the output register once it is free.
        ST_EMIT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The table count never passes its size.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(MAX_RANGES))
    else $error("range count above table size");

  // An open segment always has registers left to cut.
  a_seg_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_open_q |-> (seg_next_q < seg_end_q))
    else $error("open segment is empty");

  // Error and no-plan results end the plan and carry no request.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != STATUS_REQ))
      |-> (out_item_o.last && (out_item_o.req_count == '0)))
    else $error("status result without last or with a count");

  // A request covers between one register and the cap.
  a_req_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == STATUS_REQ))
      |-> ((out_item_o.req_count != '0) && (out_item_o.req_count <= REQ_CAP)))
    else $error("request count out of range");

endmodule

`default_nettype wire
